[sv/vlu8_pkg.sv]
// Package with shared types and constants of the variable-length to UTF-8 transcoder.
`default_nettype none
package vlu8_pkg;

  // Widths of the held partial value and of a finished code point.
  localparam int PV_W = 14;
  localparam int CP_W = 23;

  typedef logic [CP_W-1:0] cp_t;
  typedef logic [PV_W-1:0] pv_t;

  // A finished character on its way from the front to the queue.
  typedef struct packed {
    logic valid;
    cp_t  cp;
  } char_msg_t;

  // Code point biases of the two- and three-byte forms.
  localparam cp_t TWO_BYTE_BIAS   = CP_W'(128);
  localparam cp_t THREE_BYTE_BIAS = CP_W'((1 << 14) + 128);

  // Upper bounds of the one-, two- and three-byte UTF-8 forms.
  localparam cp_t LIMIT_1 = CP_W'(128);
  localparam cp_t LIMIT_2 = CP_W'(1 << 11);
  localparam cp_t LIMIT_3 = CP_W'(1 << 16);

  // UTF-8 lead and continuation markers.
  localparam logic [7:0] LEAD_2 = 8'd192;
  localparam logic [7:0] LEAD_3 = 8'd224;
  localparam logic [7:0] LEAD_4 = 8'd240;
  localparam logic [7:0] CONT   = 8'd128;

  // Bytes seen of the character being gathered.
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  // UTF-8 length of a character, coded as byte count minus one.
  localparam logic [1:0] LEN_1 = 2'd0;
  localparam logic [1:0] LEN_2 = 2'd1;
  localparam logic [1:0] LEN_3 = 2'd2;
  localparam logic [1:0] LEN_4 = 2'd3;

  // Default depth of the character queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

endpackage
`default_nettype wire

[sv/vlu8_front.sv]
// Front end: gathers input bytes into characters and forms their code points.
`default_nettype none
module vlu8_front
  import vlu8_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire logic [7:0] in_byte,
  output char_msg_t      char_msg
);

  pv_t        partial_value;
  pv_t        partial_value_next;
  logic [1:0] bytes_seen;
  logic [1:0] bytes_seen_next;
  pv_t        pv_joined;

  always_comb begin
    pv_joined          = {in_byte[6:0], partial_value[6:0]};
    partial_value_next = '0;
    bytes_seen_next    = SEEN_NONE;
    char_msg.valid     = 1'b0;
    char_msg.cp        = '0;
    case (bytes_seen)
      SEEN_ONE: begin
        if (in_byte[7]) begin
          partial_value_next = pv_joined;
          bytes_seen_next    = SEEN_TWO;
        end else begin
          char_msg.valid = 1'b1;
          char_msg.cp    = CP_W'(pv_joined) + TWO_BYTE_BIAS;
        end
      end
      SEEN_TWO: begin
        char_msg.valid = 1'b1;
        char_msg.cp    = CP_W'(partial_value) + CP_W'({in_byte, {PV_W{1'b0}}})
                         + THREE_BYTE_BIAS;
      end
      default: begin
        // A stray count of three is handled as the start of a new character.
        if (in_byte[7]) begin
          partial_value_next = PV_W'(in_byte[6:0]);
          bytes_seen_next    = SEEN_ONE;
        end else begin
          char_msg.valid = 1'b1;
          char_msg.cp    = CP_W'(in_byte);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value <= '0;
      bytes_seen    <= SEEN_NONE;
    end else if (accept) begin
      partial_value <= partial_value_next;
      bytes_seen    <= bytes_seen_next;
    end
  end

endmodule
`default_nettype wire

[sv/vlu8_queue.sv]
// Short queue of finished code points between the front and the back end.
`default_nettype none
module vlu8_queue
  import vlu8_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cp_t  wr_data,
  input  wire logic rd_en,
  output cp_t       rd_data,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cp_t              mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/vlu8_back.sv]
// Back end: splits one code point at a time into its UTF-8 bytes.
`default_nettype none
module vlu8_back
  import vlu8_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_empty,
  input  wire cp_t        q_data,
  output logic            q_pop,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            char_done
);

  logic       active;
  cp_t        cur_cp;
  logic [1:0] cur_len;
  logic [1:0] cur_idx;
  logic [1:0] rem;
  logic [1:0] load_len;
  logic       take;

  assign empty     = !active;
  assign char_done = (cur_idx == cur_len);
  assign rem       = cur_len - cur_idx;
  assign take      = pop && active;
  assign q_pop     = !q_empty && (!active || (take && char_done));

  always_comb begin
    if (q_data < LIMIT_1) begin
      load_len = LEN_1;
    end else if (q_data < LIMIT_2) begin
      load_len = LEN_2;
    end else if (q_data < LIMIT_3) begin
      load_len = LEN_3;
    end else begin
      load_len = LEN_4;
    end
  end

  always_comb begin
    if (cur_idx == 2'd0) begin
      case (cur_len)
        LEN_1:   out_byte = cur_cp[7:0];
        LEN_2:   out_byte = LEAD_2 | {3'd0, cur_cp[10:6]};
        LEN_3:   out_byte = LEAD_3 | {4'd0, cur_cp[15:12]};
        default: out_byte = LEAD_4 | {3'd0, cur_cp[22:18]};
      endcase
    end else begin
      case (rem)
        2'd0:    out_byte = CONT | {2'd0, cur_cp[5:0]};
        2'd1:    out_byte = CONT | {2'd0, cur_cp[11:6]};
        default: out_byte = CONT | {2'd0, cur_cp[17:12]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cp  <= q_data;
      cur_len <= load_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      cur_idx <= '0;
    end else if (q_pop) begin
      active  <= 1'b1;
      cur_idx <= '0;
    end else if (take) begin
      if (char_done) begin
        active <= 1'b0;
      end else begin
        cur_idx <= cur_idx + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/varlen_to_utf8_transcoder_core.sv]
// Top level of the variable-length character code to UTF-8 transcoder.
`default_nettype none
// The block takes a stream of one- to three-byte character codes, one byte
// per item on the input queue port, and gives the UTF-8 form of each
// character, one byte per item on the result queue port, with char_done high
// on the last byte of every character. An input item is taken in any cycle in
// which full is low, so bytes may arrive back to back; a character that is not
// yet complete produces nothing, and one left unfinished is held until more
// bytes come or reset discards it. The front end gathers the bytes and forms
// the code point in the cycle the last byte arrives, then writes it into a
// queue of QUEUE_DEPTH characters. The back end reads one character at a time
// and shows one UTF-8 byte per cycle while pop is high, moving to the next
// character in the cycle after its last byte is taken. A character therefore
// yields one to four result bytes in the back end, and that emitter sets the
// sustained rate: it is lowest for two-byte characters that grow into three
// UTF-8 bytes, next lowest for three-byte characters that grow into four-byte
// UTF-8 output, and plain ASCII gives one result byte per input byte. The
// first result byte of a character passes through the queue and then the
// back end's character registers before it appears, even when both are idle.
// full rises only when the queue is full; in that case the input waits even
// for a byte that would not finish a character.
module varlen_to_utf8_transcoder_core
  import vlu8_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            char_done
);

  logic      in_accept;
  char_msg_t char_msg;
  cp_t       q_data;
  logic      q_pop;
  logic      q_empty;

  // The front end only moves when the queue can take a character.
  assign in_accept = push && !full;

  vlu8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (in_accept),
    .in_byte  (in_byte),
    .char_msg (char_msg)
  );

  vlu8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_accept && char_msg.valid),
    .wr_data (char_msg.cp),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  vlu8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .char_done (char_done)
  );

endmodule
`default_nettype wire

[tb/sv/varlen_to_utf8_transcoder_core_tb.sv]
// Testbench for the variable-length code to UTF-8 transcoder core.
`timescale 1ns / 1ps

module varlen_to_utf8_transcoder_core_tb;
  import vlu8_pkg::*;

  // The run is stopped with a failure if it is still going after this many cycles.
  localparam int CYCLE_LIMIT  = 300000;
  // Length of the long receiver hold-off that fills the block up.
  localparam int HOLD_CYCLES  = 300;
  // Number of bytes offered in each random idling phase, at least.
  localparam int PHASE_BYTES  = 12;
  // Quiet cycles after the last expected byte, to catch stray output.
  localparam int TAIL_CYCLES  = 20;
  localparam int DIR_ROWS     = 23;

  // One UTF-8 byte as the checker expects it on the result ports.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } utf8_byte_t;

  // One row of the directed table. Where n_typed is nonzero, the expected
  // UTF-8 bytes are typed in, left aligned in typed; otherwise they come
  // from the predictor.
  typedef struct packed {
    logic [7:0]  code;
    logic [2:0]  n_typed;
    logic [31:0] typed;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] in_byte = 8'd0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       char_done;

  // Predictor state: the low seven bits of the first two bytes of the
  // character being gathered, and how many of its bytes have been taken.
  logic [PV_W-1:0] held_bits = '0;
  logic [1:0]      held_count = SEEN_NONE;

  // UTF-8 bytes predicted but not yet seen on the output, oldest first.
  utf8_byte_t pending_utf8[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  // Code bytes taken by the block so far.
  int bytes_sent = 0;

  // Idling controls of the sender (idle_pct) and the receiver (stall_pct), in percent.
  int idle_pct = 0;
  int stall_pct = 0;

  // The sender asks for a hold-off by bumping hold_requests; the receiver
  // process notices the change and counts the hold-off down by itself.
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  // Directed stream: the extremes of every character length, the size
  // boundaries of the UTF-8 forms, and the largest code point, whose lead
  // byte loses its top bit.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00, 3'd1, 32'h00_00_00_00},  // smallest one-byte character
    '{8'h7F, 3'd1, 32'h7F_00_00_00},  // largest one-byte character
    '{8'h80, 3'd0, 32'h0},
    '{8'h00, 3'd2, 32'hC2_80_00_00},  // smallest two-byte character
    '{8'hFF, 3'd0, 32'h0},
    '{8'h7F, 3'd3, 32'hE4_81_BF_00},  // largest two-byte character
    '{8'h80, 3'd0, 32'h0},
    '{8'h80, 3'd0, 32'h0},
    '{8'h00, 3'd3, 32'hE4_82_80_00},  // smallest three-byte character
    '{8'hFF, 3'd0, 32'h0},
    '{8'hFF, 3'd0, 32'h0},
    '{8'hFF, 3'd4, 32'hF0_84_81_BF},  // largest code point, no range check
    '{8'hFF, 3'd0, 32'h0},
    '{8'h0E, 3'd0, 32'h0},            // top of the two-byte UTF-8 form
    '{8'h80, 3'd0, 32'h0},
    '{8'h0F, 3'd0, 32'h0},            // bottom of the three-byte UTF-8 form
    '{8'hFF, 3'd0, 32'h0},
    '{8'hFE, 3'd0, 32'h0},
    '{8'h02, 3'd0, 32'h0},            // top of the three-byte UTF-8 form
    '{8'h80, 3'd0, 32'h0},
    '{8'hFF, 3'd0, 32'h0},
    '{8'h02, 3'd0, 32'h0},            // bottom of the four-byte UTF-8 form
    '{8'h55, 3'd0, 32'h0}
  };

  varlen_to_utf8_transcoder_core DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .char_done (char_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("ERROR at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Takes one code byte into the predictor state. When the byte completes a
  // character, returns the number of UTF-8 bytes it yields, with the bytes
  // left aligned in utf8; otherwise returns zero.
  function automatic int utf8_for_byte(input logic [7:0] code, output logic [31:0] utf8);
    logic [23:0] cp;
    utf8 = '0;
    case (held_count)
      SEEN_ONE: begin
        held_bits = {code[6:0], held_bits[6:0]};
        if (code[7]) begin
          held_count = SEEN_TWO;
          return 0;
        end
        cp = 24'(held_bits) + 24'(TWO_BYTE_BIAS);
      end
      SEEN_TWO: begin
        // The third byte ends the character whatever its top bit says.
        cp = 24'(held_bits) + (24'(code) << 14) + 24'(THREE_BYTE_BIAS);
      end
      default: begin
        // Also covers a count that should never occur: start afresh.
        if (code[7]) begin
          held_bits = {7'd0, code[6:0]};
          held_count = SEEN_ONE;
          return 0;
        end
        cp = 24'(code);
      end
    endcase
    held_bits = '0;
    held_count = SEEN_NONE;
    if (cp < 24'(LIMIT_1)) begin
      utf8 = {cp[7:0], 24'd0};
      return 1;
    end
    if (cp < 24'(LIMIT_2)) begin
      utf8 = {LEAD_2 | 8'(cp >> 6), CONT | {2'b00, cp[5:0]}, 16'd0};
      return 2;
    end
    if (cp < 24'(LIMIT_3)) begin
      utf8 = {LEAD_3 | 8'(cp >> 12), CONT | {2'b00, cp[11:6]},
              CONT | {2'b00, cp[5:0]}, 8'd0};
      return 3;
    end
    // Only the low eight bits of the lead byte survive for the largest values.
    utf8 = {LEAD_4 | 8'(cp >> 18), CONT | {2'b00, cp[17:12]},
            CONT | {2'b00, cp[11:6]}, CONT | {2'b00, cp[5:0]}};
    return 4;
  endfunction

  // Offers one code byte until the block takes it, then queues the UTF-8
  // bytes it is expected to produce. Gaps before the offer follow idle_pct.
  task automatic send_code_byte(input logic [7:0] code, input logic [2:0] n_typed,
                                input logic [31:0] typed);
    logic [31:0] utf8;
    int          n;
    bit          taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    in_byte <= code;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !full;
    end
    bytes_sent++;
    n = utf8_for_byte(code, utf8);
    if (n_typed != 3'd0) begin
      n = n_typed;
      utf8 = typed;
    end
    for (int k = 0; k < n; k++)
      pending_utf8.push_back('{utf8[31 - 8*k -: 8], k == n - 1});
  endtask

  // Sends one random character. Most are well formed with random content,
  // steered so that every UTF-8 length turns up; one in ten is a random byte.
  // Three-byte characters with a large last byte give four UTF-8 bytes.
  task automatic send_random_char(input bit force_long);
    int kind;
    kind = force_long ? 9 : $urandom_range(0, 9);
    if (kind == 0) begin
      send_code_byte(8'($urandom_range(0, 255)), 3'd0, 32'h0);
    end else if (kind <= 3) begin
      send_code_byte(8'($urandom_range(0, 127)), 3'd0, 32'h0);
    end else if (kind <= 6) begin
      send_code_byte(8'($urandom_range(128, 255)), 3'd0, 32'h0);
      send_code_byte(8'($urandom_range(0, 127)), 3'd0, 32'h0);
    end else begin
      send_code_byte(8'($urandom_range(128, 255)), 3'd0, 32'h0);
      send_code_byte(8'($urandom_range(128, 255)), 3'd0, 32'h0);
      if (force_long || $urandom_range(0, 1) == 0)
        send_code_byte(8'($urandom_range(3, 255)), 3'd0, 32'h0);
      else
        send_code_byte(8'($urandom_range(0, 3)), 3'd0, 32'h0);
    end
  endtask

  // Stops offering and waits until every expected UTF-8 byte has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending_utf8.size() != 0)
      @(posedge clk);
  endtask

  // Receiver: pops at random according to stall_pct, or holds off entirely
  // for HOLD_CYCLES once a hold-off has been asked for.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Checker: every UTF-8 byte taken from the block is compared with the
  // oldest expected one. It also keeps the cycle count for the time limit.
  always @(posedge clk) begin
    utf8_byte_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
    if (!rst && pop && !empty) begin
      if (pending_utf8.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %h char_done %b", out_byte, char_done));
      end else begin
        want = pending_utf8.pop_front();
        if (out_byte !== want.value)
          report_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.value));
        if (char_done !== want.last)
          report_mismatch($sformatf("char_done %b, expected %b on byte %h",
                                    char_done, want.last, want.value));
      end
    end
  end

  initial begin
    int phase_start;
    // Synchronous reset, released on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, with no idling on either side.
    for (int r = 0; r < DIR_ROWS; r++)
      send_code_byte(dir_rows[r].code, dir_rows[r].n_typed, dir_rows[r].typed);
    // The sender pauses here until every expected byte has come.
    wait_for_drain();

    // Random phases: no idling, sender idling, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES)
        send_random_char(1'b0);
      wait_for_drain();
    end

    // Back pressure: the receiver holds off while the sender keeps offering
    // characters that grow into four UTF-8 bytes, so the block fills and
    // raises full.
    idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    for (int k = 0; k < 10; k++)
      send_random_char(1'b1);

    // A character left unfinished at the end of the stream yields nothing.
    send_code_byte(8'($urandom_range(128, 255)), 3'd0, 32'h0);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
